### hdl/uutp_pkg.sv
// Shared types, character constants and helpers for the UUID text parser.
`timescale 1ns / 1ps

package uutp_pkg;

    localparam int UUID_LEN = 36;
    localparam int POS_W    = 6;
    // Digits at positions below this boundary go to the high word.
    localparam int HIGH_END = 18;

    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [3:0] NIBBLE_TEN   = 4'd10;

    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(UUID_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(UUID_LEN - 1);
    localparam logic [POS_W-1:0] POS_HIGH = POS_W'(HIGH_END);

    typedef struct packed {
        logic       is_hex;
        logic       is_dash;
        logic [3:0] nibble;
    } char_class_t;

    function automatic logic is_dash_pos(input logic [POS_W-1:0] pos);
        return (pos == POS_W'(8)) || (pos == POS_W'(13)) ||
               (pos == POS_W'(18)) || (pos == POS_W'(23));
    endfunction

endpackage

### hdl/uutp_char_class.sv
// Character classifier: dash detect and hex digit decode.
`timescale 1ns / 1ps

module uutp_char_class
    import uutp_pkg::*;
(
    input  logic [7:0]  char_code,
    output char_class_t char_class
);

    logic       is_dec;
    logic       is_lower;
    logic       is_upper;
    logic [7:0] dec_off;
    logic [7:0] lower_off;
    logic [7:0] upper_off;

    always_comb begin
        is_dec    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        is_lower  = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
        is_upper  = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);
        dec_off   = char_code - CHAR_ZERO;
        lower_off = char_code - CHAR_LOWER_A;
        upper_off = char_code - CHAR_UPPER_A;

        char_class.is_dash = (char_code == CHAR_DASH);
        char_class.is_hex  = is_dec || is_lower || is_upper;
        if (is_dec) begin
            char_class.nibble = dec_off[3:0];
        end else if (is_lower) begin
            char_class.nibble = lower_off[3:0] + NIBBLE_TEN;
        end else if (is_upper) begin
            char_class.nibble = upper_off[3:0] + NIBBLE_TEN;
        end else begin
            char_class.nibble = 4'd0;
        end
    end

endmodule

### hdl/uuid_text_parser.sv
// Top level of the UUID text parser: position tracking, accumulators, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  s_      | in        | s_tvalid / s_tready | s_tdata = char_code, s_tlast = final_char
//  m_      | out       | m_tvalid / m_tready | m_tdata = {low_word, high_word},
//          |           |                     | m_tuser = parse_ok
//
// One character is taken per cycle while s_tready is high; classify, shift and check
// fit between the input port and the state/result registers.
// A result appears in the cycle after the transaction that carries tlast.
// s_tready drops only while a result sits in the output register and m_tready is low.
// aresetn clears the position counter, accumulators, error flag and result valid.
`timescale 1ns / 1ps

module uuid_text_parser
    import uutp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tlast,   // final_char
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] high_word, [127:64] low_word
    output logic [0:0]   m_tuser    // [0] parse_ok
);

    char_class_t      cls;
    logic             s_fire;
    logic             pos_dash;
    logic             char_bad;
    logic             ok_now;

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [63:0]      high_reg, high_next;
    logic [63:0]      low_reg,  low_next;
    logic             bad_reg,  bad_next;
    logic             out_valid_reg, out_valid_next;
    logic [127:0]     out_data_reg,  out_data_next;
    logic             out_ok_reg,    out_ok_next;

    uutp_char_class u_char_class (
        .char_code  (s_tdata),
        .char_class (cls)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign pos_dash = is_dash_pos(pos_reg);

    always_comb begin
        pos_next       = pos_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;
        char_bad       = 1'b0;
        ok_now         = 1'b0;

        if (s_fire) begin
            if (pos_reg >= POS_MAX) begin
                char_bad = 1'b1;
            end else begin
                if (pos_dash) begin
                    char_bad = !cls.is_dash;
                end else if (!cls.is_hex) begin
                    char_bad = 1'b1;
                end else if (pos_reg < POS_HIGH) begin
                    high_next = {high_reg[59:0], cls.nibble};
                end else begin
                    low_next = {low_reg[59:0], cls.nibble};
                end
                pos_next = pos_reg + POS_W'(1);
            end
            bad_next = bad_reg || char_bad;

            if (s_tlast) begin
                ok_now         = (pos_reg == POS_LAST) && !bad_next;
                out_valid_next = 1'b1;
                out_ok_next    = ok_now;
                out_data_next  = ok_now ? {low_next, high_next} : 128'd0;
                // start over for the next string
                pos_next  = '0;
                high_next = '0;
                low_next  = '0;
                bad_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ok_reg;

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("position counter beyond string length");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 128'd0)
        else $error("failed parse carries nonzero words");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> pos_reg == '0 && !bad_reg)
        else $error("state not cleared after final character");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("final character produced no result");

    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready && s_tlast) && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("result appeared without a final character");

endmodule
